/* rtl/distinct_value_two_class_counter_defines.svh */
// Assertion macros shared by the distinct value counter RTL
`ifndef DISTINCT_VALUE_TWO_CLASS_COUNTER_DEFINES_SVH
`define DISTINCT_VALUE_TWO_CLASS_COUNTER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define DVTCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication, checked out of reset
`define DVTCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define DVTCC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DVTCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/dvtcc_pkg.sv */
// Types, constants and helper functions of the distinct value counter
`timescale 1ns / 1ps

package dvtcc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int IDX_W       = 6;
    localparam int USED_W      = 7;
    localparam int VAL_W       = 64;

    // operation codes
    localparam logic [1:0] OP_COUNT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_UNUSED = 2'd2;

    localparam logic [VAL_W-1:0] ABS_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] EXP_MASK = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic [1:0]       operation;
        logic             population;
        logic [VAL_W-1:0] value_bits;
        logic [IDX_W-1:0] read_index;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]             status;
        logic                   was_found;
        logic [IDX_W-1:0]       entry_position;
        logic [VAL_W-1:0]       entry_value;
        logic [COUNT_WIDTH-1:0] first_count;
        logic [COUNT_WIDTH-1:0] second_count;
        logic [USED_W-1:0]      entries_used;
    } t_out_beat;

    // one entry as it travels along the gather chain
    typedef struct packed {
        logic [IDX_W-1:0]       position;
        logic [VAL_W-1:0]       value;
        logic [COUNT_WIDTH-1:0] first_count;
        logic [COUNT_WIDTH-1:0] second_count;
    } t_slot;

    // operand broadcast to every cell
    typedef struct packed {
        logic [1:0]        operation;
        logic              population;
        logic [VAL_W-1:0]  value_bits;
        logic [IDX_W-1:0]  read_index;
        logic [USED_W-1:0] used;
    } t_bcast;

    // phase strobes and global flags for the cells
    typedef struct packed {
        logic cmp;
        logic upd;
        logic any_hit;
        logic room;
    } t_ctrl;

    function automatic logic is_nan(input logic [VAL_W-1:0] b);
        return (b & ABS_MASK) > EXP_MASK;
    endfunction

    // IEEE equality on raw bits: signed zeros match, NaN matches nothing
    function automatic logic dbl_equal(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        logic res;
        if (is_nan(a) || is_nan(b)) begin
            res = 1'b0;
        end else if (((a & ABS_MASK) == '0) && ((b & ABS_MASK) == '0)) begin
            res = 1'b1;
        end else begin
            res = (a == b);
        end
        return res;
    endfunction

    // saturating increment
    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

/* rtl/distinct_value_two_class_counter.sv */
// Top level: command port, sequencer and row of entry cells
`timescale 1ns / 1ps
`include "distinct_value_two_class_counter_defines.svh"

// Table of up to 64 distinct double values, each with two saturating
// counters. One command is taken when start is high and busy is low;
// busy then stays high through the CMP, UPD, GATHER and MERGE states.
// The result beat is registered in MERGE and appears on o_result with
// o_valid high for exactly one cycle. A new command can be taken in the
// cycle the result is shown, but not before the last one is through. The
// cell row does the work in order: compare in all cells, update the
// matching or appended cell, gather along chains of eight cells and
// merge the chain ends. The result is not held: the receiver must take
// it in the cycle it is shown. The table comes up empty after reset and
// needs no clearing pass.
module distinct_value_two_class_counter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  dvtcc_pkg::t_in_beat  i_cmd,
    output logic                 o_valid,
    output dvtcc_pkg::t_out_beat o_result
);

    localparam int DEPTH = dvtcc_pkg::TABLE_DEPTH;
    localparam int GSZ   = dvtcc_pkg::GROUP_SIZE;
    localparam int NGRP  = dvtcc_pkg::NUM_GROUPS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMP    = 3'd1;
    localparam logic [2:0] S_UPD    = 3'd2;
    localparam logic [2:0] S_GATHER = 3'd3;
    localparam logic [2:0] S_MERGE  = 3'd4;

    localparam logic [dvtcc_pkg::USED_W-1:0] DEPTH_USED = dvtcc_pkg::USED_W'(DEPTH);

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    dvtcc_pkg::t_in_beat            r_cmd;
    logic [dvtcc_pkg::USED_W-1:0]   r_used;
    logic                           r_any_hit;
    logic                           r_full;
    logic                           r_rd_ok;
    dvtcc_pkg::t_slot               r_grp [NGRP];
    dvtcc_pkg::t_out_beat           r_out;
    logic                           r_valid;

    dvtcc_pkg::t_bcast              w_bcast;
    dvtcc_pkg::t_ctrl               w_ctrl;
    dvtcc_pkg::t_slot               w_link_in  [DEPTH];
    dvtcc_pkg::t_slot               w_link_out [DEPTH];
    logic [DEPTH-1:0]               w_hits;
    logic                           w_any_hit;
    logic                           w_room;
    logic                           w_is_count;
    dvtcc_pkg::t_slot               w_merged;
    dvtcc_pkg::t_out_beat           w_out;

    assign busy       = (r_state != S_IDLE);
    assign w_any_hit  = |w_hits;
    assign w_room     = r_used < DEPTH_USED;
    assign w_is_count = (r_cmd.operation == dvtcc_pkg::OP_COUNT);

    // broadcast operand and phase strobes
    always_comb begin
        w_bcast.operation  = r_cmd.operation;
        w_bcast.population = r_cmd.population;
        w_bcast.value_bits = r_cmd.value_bits;
        w_bcast.read_index = r_cmd.read_index;
        w_bcast.used       = r_used;
        w_ctrl.cmp         = (r_state == S_CMP);
        w_ctrl.upd         = (r_state == S_UPD);
        w_ctrl.any_hit     = w_any_hit;
        w_ctrl.room        = w_room;
    end

    // row of cells, linked in chains of GSZ
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        if ((gi % GSZ) == 0) begin : g_head
            assign w_link_in[gi] = '0;
        end else begin : g_body
            assign w_link_in[gi] = w_link_out[gi-1];
        end
        dvtcc_cell #(
            .CELL_POS (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bcast (w_bcast),
            .i_ctrl  (w_ctrl),
            .i_link  (w_link_in[gi]),
            .o_link  (w_link_out[gi]),
            .o_hit   (w_hits[gi])
        );
    end

    // capture the chain ends
    for (genvar gg = 0; gg < NGRP; gg++) begin : g_grp
        localparam int TAIL = ((gg + 1) * GSZ > DEPTH) ? DEPTH - 1 : (gg + 1) * GSZ - 1;
        always_ff @(posedge i_clk) begin
            if (r_state == S_GATHER) begin
                r_grp[gg] <= w_link_out[TAIL];
            end
        end
    end

    // merge the chain ends
    always_comb begin
        w_merged = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_merged = w_merged | r_grp[g];
        end
    end

    // build the result beat
    always_comb begin
        w_out = '0;
        w_out.entries_used = r_used;
        priority if (w_is_count && r_full) begin
            w_out.status      = dvtcc_pkg::ST_FULL;
            w_out.entry_value = r_cmd.value_bits;
        end else if (w_is_count) begin
            w_out.was_found      = r_any_hit;
            w_out.entry_position = w_merged.position;
            w_out.entry_value    = w_merged.value;
            w_out.first_count    = w_merged.first_count;
            w_out.second_count   = w_merged.second_count;
        end else if (r_cmd.operation == dvtcc_pkg::OP_READ && r_rd_ok) begin
            w_out.entry_position = w_merged.position;
            w_out.entry_value    = w_merged.value;
            w_out.first_count    = w_merged.first_count;
            w_out.second_count   = w_merged.second_count;
        end else if (r_cmd.operation == dvtcc_pkg::OP_READ) begin
            w_out.status = dvtcc_pkg::ST_UNUSED;
        end else begin
            w_out.status = dvtcc_pkg::ST_OK;
        end
    end

    // advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) begin
                n_state = S_CMP;
            end
            S_CMP:    n_state = S_UPD;
            S_UPD:    n_state = S_GATHER;
            S_GATHER: n_state = S_MERGE;
            S_MERGE:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state: sequencer, fill count, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_MERGE);
            if (r_state == S_UPD) begin
                if (r_cmd.operation == dvtcc_pkg::OP_CLEAR) begin
                    r_used <= '0;
                end else if (w_is_count && !w_any_hit && w_room) begin
                    r_used <= r_used + 1'b1;
                end
            end
        end
    end

    // hold command, flags and result beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_CMP) begin
            r_rd_ok <= dvtcc_pkg::USED_W'(r_cmd.read_index) < r_used;
        end
        if (r_state == S_UPD) begin
            r_any_hit <= w_any_hit;
            r_full    <= !w_any_hit && !w_room;
        end
        if (r_state == S_MERGE) begin
            r_out <= w_out;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

    `DVTCC_ASSERT_IMPL(a_single_hit, i_clk, i_rst_n, r_state == S_UPD, $onehot0(w_hits))
    `DVTCC_ASSERT_IMPL(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= DEPTH_USED)
    `DVTCC_ASSERT_NEXT(a_strobe_after_merge, i_clk, i_rst_n, r_state == S_MERGE, o_valid)
    `DVTCC_ASSERT_NEXT(a_accept_to_cmp, i_clk, i_rst_n, start && !busy, r_state == S_CMP)

endmodule

/* rtl/dvtcc_cell.sv */
// One table entry: value, two counters, compare and update, gather link
`timescale 1ns / 1ps

module dvtcc_cell #(
    parameter int CELL_POS = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dvtcc_pkg::t_bcast i_bcast,
    input  dvtcc_pkg::t_ctrl  i_ctrl,
    input  dvtcc_pkg::t_slot  i_link,
    output dvtcc_pkg::t_slot  o_link,
    output logic             o_hit
);

    localparam logic [dvtcc_pkg::IDX_W-1:0]  POS_IDX  = dvtcc_pkg::IDX_W'(CELL_POS);
    localparam logic [dvtcc_pkg::USED_W-1:0] POS_USED = dvtcc_pkg::USED_W'(CELL_POS);

    logic [dvtcc_pkg::VAL_W-1:0]       r_value;
    logic [dvtcc_pkg::COUNT_WIDTH-1:0] r_cnt0;
    logic [dvtcc_pkg::COUNT_WIDTH-1:0] r_cnt1;
    logic                              r_hit;
    logic                              r_rd;
    logic                              r_sel;
    logic                              w_valid;
    logic                              w_append;
    dvtcc_pkg::t_slot                  w_own;

    assign w_valid  = POS_USED < i_bcast.used;
    assign w_append = (i_bcast.operation == dvtcc_pkg::OP_COUNT) && !i_ctrl.any_hit
                      && i_ctrl.room && (i_bcast.used == POS_USED);

    // compare and select flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_rd  <= 1'b0;
            r_sel <= 1'b0;
        end else begin
            if (i_ctrl.cmp) begin
                r_hit <= w_valid && (i_bcast.operation == dvtcc_pkg::OP_COUNT)
                         && dvtcc_pkg::dbl_equal(i_bcast.value_bits, r_value);
                r_rd  <= w_valid && (i_bcast.operation == dvtcc_pkg::OP_READ)
                         && (i_bcast.read_index == POS_IDX);
            end
            if (i_ctrl.upd) begin
                r_sel <= r_hit || r_rd || w_append;
            end
        end
    end

    // bump on a hit, load on an append
    always_ff @(posedge i_clk) begin
        if (i_ctrl.upd) begin
            if (r_hit) begin
                if (i_bcast.population) begin
                    r_cnt1 <= dvtcc_pkg::bump(r_cnt1);
                end else begin
                    r_cnt0 <= dvtcc_pkg::bump(r_cnt0);
                end
            end else if (w_append) begin
                r_value <= i_bcast.value_bits;
                r_cnt0  <= i_bcast.population ? '0 : dvtcc_pkg::COUNT_WIDTH'(1);
                r_cnt1  <= i_bcast.population ? dvtcc_pkg::COUNT_WIDTH'(1) : '0;
            end
        end
    end

    // merge own entry into the link when selected
    always_comb begin
        w_own.position     = POS_IDX;
        w_own.value        = r_value;
        w_own.first_count  = r_cnt0;
        w_own.second_count = r_cnt1;
        o_link = i_link | (r_sel ? w_own : '0);
    end

    assign o_hit = r_hit;

endmodule
